// ===== rtl/core/srr_pkg.sv =====
// Shared types and constants of the stepper speed ramp block.
// Holds the transfer payloads, the register map, the sequencer states and
// the request bundles of the serial arithmetic units. No dependencies.
package srr_pkg;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MAX_ACCEL   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CRUISE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KNEE        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_ACCEL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BRAKE_DIV   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_PERIOD = 3'd6;

  localparam int unsigned MUL_A_W = 15;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = 31;
  localparam int unsigned DIV_N_W = 32;
  localparam int unsigned DIV_D_W = 23;
  localparam int unsigned DIV_C_W = 6;

  localparam logic [20:0] TIMER_HZ   = 21'd2000000;
  localparam logic [9:0]  US_PER_MS  = 10'd1000;
  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [31:0] DIV_SAT    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [14:0] max_accel;
    logic [14:0] cruise_speed;
    logic [14:0] speed_limit;
    logic [14:0] low_speed_knee;
    logic [14:0] start_accel;
    logic [7:0]  brake_div;
    logic [15:0] idle_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_accel:      15'd1000,
    cruise_speed:   15'd0,
    speed_limit:    15'd32000,
    low_speed_knee: 15'd2500,
    start_accel:    15'd100,
    brake_div:      8'd2,
    idle_period:    16'hFFFF
  };

  typedef struct packed {
    logic        [15:0] dt_us;
    logic signed [31:0] goal_step;
    logic signed [31:0] current_step;
  } in_t;

  typedef struct packed {
    logic signed [15:0] speed_out;
    logic        [15:0] step_period;
    logic               direction_level;
    logic        [14:0] accel_used;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_C_W-1:0] len;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ACC_MUL  = 10'b00_0000_0010,
    S_ACC_DIV  = 10'b00_0000_0100,
    S_SD_MUL1  = 10'b00_0000_1000,
    S_SD_MUL2  = 10'b00_0001_0000,
    S_SD_DIV   = 10'b00_0010_0000,
    S_RAMP_MUL = 10'b00_0100_0000,
    S_RAMP_DIV = 10'b00_1000_0000,
    S_PER_DIV  = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } seq_state_e;

endpackage

// ===== rtl/core/srr_regs.sv =====
// Configuration register file of the stepper speed ramp, on an APB-style port.
// Depends on srr_pkg for the register map and the configuration struct.
module srr_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srr_pkg::ADDR_W-1:0]  paddr,
  input  logic [srr_pkg::DATA_W-1:0]  pwdata,
  output logic [srr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output srr_pkg::cfg_t               cfg_o
);
  import srr_pkg::*;

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_ACCEL:   cfg_q.max_accel      <= pwdata[14:0];
        REG_CRUISE:      cfg_q.cruise_speed   <= pwdata[14:0];
        REG_SPEED_LIMIT: cfg_q.speed_limit    <= pwdata[14:0];
        REG_KNEE:        cfg_q.low_speed_knee <= pwdata[14:0];
        REG_START_ACCEL: cfg_q.start_accel    <= pwdata[14:0];
        REG_BRAKE_DIV:   cfg_q.brake_div      <= pwdata[7:0];
        REG_IDLE_PERIOD: cfg_q.idle_period    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_ACCEL:   prdata = {17'd0, cfg_q.max_accel};
      REG_CRUISE:      prdata = {17'd0, cfg_q.cruise_speed};
      REG_SPEED_LIMIT: prdata = {17'd0, cfg_q.speed_limit};
      REG_KNEE:        prdata = {17'd0, cfg_q.low_speed_knee};
      REG_START_ACCEL: prdata = {17'd0, cfg_q.start_accel};
      REG_BRAKE_DIV:   prdata = {24'd0, cfg_q.brake_div};
      REG_IDLE_PERIOD: prdata = {16'd0, cfg_q.idle_period};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/srr_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero. Depends on srr_pkg.
module srr_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srr_pkg::mul_req_t             req_i,
  output logic                          done_o,
  output logic [srr_pkg::MUL_P_W-1:0]   prod_o
);
  import srr_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [MUL_P_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] acc_q;

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= {{(MUL_P_W-MUL_A_W){1'b0}}, req_i.a};
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[MUL_P_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MUL_B_W-1:1]};
    end
  end

endmodule

// ===== rtl/core/srr_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// The dividend arrives aligned to its top bit with its length. Depends on srr_pkg.
module srr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srr_pkg::div_req_t             req_i,
  output logic                          done_o,
  output logic [srr_pkg::DIV_N_W-1:0]   quot_o
);
  import srr_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DIV_C_W-1:0] cnt_q;
  logic [DIV_N_W-1:0] dvd_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_D_W-1:0] dsr_q;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W:0]   rem_sub;
  logic               ge;

  assign rem_sh  = {rem_q, dvd_q[DIV_N_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign done_o  = done_q;
  assign quot_o  = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.len;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_C_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      dvd_q <= {dvd_q[DIV_N_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/stepper_speed_ramp_top.sv =====
// Top level of the stepper speed ramp: tick sequencer, speed state and output
// register. Depends on srr_pkg, srr_regs, srr_mul and srr_div.
//
//   Channel  Signals                               Carries
//   in       in_valid_i / in_ready_o / in_data_i   one tick (dt, goal, position)
//   out      out_valid_o / out_ready_i / out_data_o speed, period, direction, accel
//   cfg      psel penable pwrite paddr pwdata ...  seven registers at 4*index
//
// One tick runs through a serial multiplier and a serial divider in turn.
// A new tick is taken only when the sequencer is idle. A result waits in the
// output register while the next tick is already being worked on.
// Reset clears the speed to zero, the direction pin to low and loads the
// register defaults.
module stepper_speed_ramp_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  srr_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output srr_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srr_pkg::ADDR_W-1:0]  paddr,
  input  logic [srr_pkg::DATA_W-1:0]  pwdata,
  output logic [srr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import srr_pkg::*;

  cfg_t               cfg;
  mul_req_t           mul_req;
  div_req_t           div_req;
  logic               mul_done;
  logic               div_done;
  logic [MUL_P_W-1:0] prod;
  logic [DIV_N_W-1:0] quot;

  seq_state_e         state_q, state_d;
  logic               launch_q, launch_d;

  logic signed [15:0] spd_q;
  logic               dir_q;
  logic [15:0]        dt_q;
  logic signed [32:0] togo_q;
  logic [14:0]        abs_q;
  logic [14:0]        accel_q;
  logic [22:0]        dsr_q;
  logic [31:0]        smag_q;
  logic signed [15:0] target_q;
  logic signed [16:0] diff_q;
  logic [15:0]        period_q;
  out_t               out_q;
  logic               out_valid_q;

  logic [15:0]        neg_spd;
  logic [14:0]        abs_spd;
  logic               below_knee;
  logic               span_neg;
  logic [14:0]        span_mag;
  logic [14:0]        accel_int;
  logic               fwd;
  logic signed [33:0] smag_ext;
  logic signed [33:0] stop_dist;
  logic signed [33:0] togo_ext;
  logic               hold_zero;
  logic [14:0]        cmag;
  logic signed [15:0] target_c;
  logic signed [22:0] diff_ext;
  logic signed [22:0] ramp_ext;
  logic               ramp_up;
  logic               ramp_dn;
  logic [15:0]        nspd;
  logic               out_free;

  srr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  srr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign neg_spd    = 16'd0 - spd_q;
  assign abs_spd    = spd_q[15] ? neg_spd[14:0] : spd_q[14:0];
  assign below_knee = abs_spd < cfg.low_speed_knee;
  assign span_neg   = cfg.max_accel < cfg.start_accel;
  assign span_mag   = span_neg ? (cfg.start_accel - cfg.max_accel)
                               : (cfg.max_accel - cfg.start_accel);
  assign accel_int  = span_neg ? (cfg.start_accel - quot[14:0])
                               : (cfg.start_accel + quot[14:0]);

  assign fwd       = !togo_q[32] && (togo_q != '0);
  assign smag_ext  = $signed({2'b00, smag_q});
  assign stop_dist = spd_q[15] ? -smag_ext : ((spd_q == '0) ? '0 : smag_ext);
  assign togo_ext  = $signed({togo_q[32], togo_q});
  assign hold_zero = fwd ? (stop_dist >= togo_ext) : (stop_dist <= togo_ext);
  assign cmag      = (cfg.cruise_speed < cfg.speed_limit) ? cfg.cruise_speed
                                                          : cfg.speed_limit;
  assign target_c  = hold_zero ? '0 : (fwd ? $signed({1'b0, cmag})
                                           : -$signed({1'b0, cmag}));

  assign diff_ext = $signed({{6{diff_q[16]}}, diff_q});
  assign ramp_ext = $signed({1'b0, quot[21:0]});
  assign ramp_up  = diff_ext > ramp_ext;
  assign ramp_dn  = diff_ext < -ramp_ext;
  assign nspd     = ramp_up ? (spd_q + quot[15:0])
                            : (ramp_dn ? (spd_q - quot[15:0]) : target_q);

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      S_ACC_MUL: begin
        mul_req.start = launch_q;
        mul_req.a     = span_mag;
        mul_req.b     = {1'b0, abs_q};
      end
      S_SD_MUL1: begin
        mul_req.start = launch_q;
        mul_req.a     = accel_q;
        mul_req.b     = {8'd0, cfg.brake_div};
      end
      S_SD_MUL2: begin
        mul_req.start = launch_q;
        mul_req.a     = abs_q;
        mul_req.b     = {1'b0, abs_q};
      end
      S_RAMP_MUL: begin
        mul_req.start = launch_q;
        mul_req.a     = accel_q;
        mul_req.b     = dt_q;
      end
      S_ACC_DIV: begin
        div_req.start    = launch_q;
        div_req.dividend = {prod[29:0], 2'b00};
        div_req.len      = DIV_C_W'(30);
        div_req.divisor  = {8'd0, cfg.low_speed_knee};
      end
      S_SD_DIV: begin
        div_req.start    = launch_q;
        div_req.dividend = {prod[29:0], 2'b00};
        div_req.len      = DIV_C_W'(30);
        div_req.divisor  = dsr_q;
      end
      S_RAMP_DIV: begin
        div_req.start    = launch_q;
        div_req.dividend = {prod[30:0], 1'b0};
        div_req.len      = DIV_C_W'(31);
        div_req.divisor  = {13'd0, US_PER_MS};
      end
      S_PER_DIV: begin
        div_req.start    = launch_q;
        div_req.dividend = {TIMER_HZ, 11'd0};
        div_req.len      = DIV_C_W'(21);
        div_req.divisor  = {8'd0, abs_spd};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          launch_d = 1'b1;
          state_d  = below_knee ? S_ACC_MUL : S_SD_MUL1;
        end
      end
      S_ACC_MUL: begin
        if (mul_done) begin
          launch_d = 1'b1;
          state_d  = S_ACC_DIV;
        end
      end
      S_ACC_DIV: begin
        if (div_done) begin
          launch_d = 1'b1;
          state_d  = S_SD_MUL1;
        end
      end
      S_SD_MUL1: begin
        if (mul_done) begin
          launch_d = 1'b1;
          state_d  = S_SD_MUL2;
        end
      end
      S_SD_MUL2: begin
        if (mul_done) begin
          launch_d = 1'b1;
          state_d  = (dsr_q == '0) ? S_RAMP_MUL : S_SD_DIV;
        end
      end
      S_SD_DIV: begin
        if (div_done) begin
          launch_d = 1'b1;
          state_d  = S_RAMP_MUL;
        end
      end
      S_RAMP_MUL: begin
        if (mul_done) begin
          launch_d = 1'b1;
          state_d  = S_RAMP_DIV;
        end
      end
      S_RAMP_DIV: begin
        if (div_done) begin
          launch_d = nspd != '0;
          state_d  = (nspd == '0) ? S_DONE : S_PER_DIV;
        end
      end
      S_PER_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      spd_q       <= '0;
      dir_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_RAMP_DIV && div_done) begin
        spd_q <= $signed(nspd);
        if (nspd != '0) begin
          dir_q <= !nspd[15];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dt_q    <= in_data_i.dt_us;
          togo_q  <= {in_data_i.goal_step[31], in_data_i.goal_step}
                   - {in_data_i.current_step[31], in_data_i.current_step};
          abs_q   <= abs_spd;
          accel_q <= cfg.max_accel;
        end
      end
      S_ACC_DIV: begin
        if (div_done) begin
          accel_q <= accel_int;
        end
      end
      S_SD_MUL1: begin
        if (mul_done) begin
          dsr_q <= prod[22:0];
        end
      end
      S_SD_MUL2: begin
        if (mul_done && (dsr_q == '0)) begin
          smag_q <= DIV_SAT;
        end
      end
      S_SD_DIV: begin
        if (div_done) begin
          smag_q <= quot;
        end
      end
      S_RAMP_MUL: begin
        if (launch_q) begin
          target_q <= target_c;
        end
        if (mul_done) begin
          diff_q <= {target_q[15], target_q} - {spd_q[15], spd_q};
        end
      end
      S_RAMP_DIV: begin
        if (div_done && (nspd == '0)) begin
          period_q <= cfg.idle_period;
        end
      end
      S_PER_DIV: begin
        if (div_done) begin
          period_q <= (quot > {16'd0, PERIOD_MAX}) ? cfg.idle_period : quot[15:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q.speed_out       <= spd_q;
          out_q.step_period     <= period_q;
          out_q.direction_level <= dir_q;
          out_q.accel_used      <= accel_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/stepper_speed_ramp_top_tb.sv =====
// Self-checking testbench for stepper_speed_ramp_top: directed ticks, then random move profiles
// under several register settings, with every result checked by a fixed value or a cycle-free
// predictor. Depends on srr_pkg and the stepper_speed_ramp_top RTL.
module stepper_speed_ramp_top_tb;
  import srr_pkg::*;

  localparam int N_PHASES    = 7;
  localparam int PHASE_ITEMS = 235;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_e;
  typedef enum bit {CHK_PRED, CHK_FIXED} chk_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          val;
    in_t                  tick;
    chk_e                 chk;
    out_t                 want;
  } row_t;

  localparam int N_ROWS = 25;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd1000, 32'sd1000, 32'sd0},
      CHK_FIXED, '{16'sd0, 16'd65535, 1'b0, 15'd100}},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd65535, POS_MAX, POS_MIN},
      CHK_FIXED, '{16'sd0, 16'd65535, 1'b0, 15'd100}},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd0, POS_MIN, POS_MAX},
      CHK_FIXED, '{16'sd0, 16'd65535, 1'b0, 15'd100}},
    '{ROW_CFG, REG_MAX_ACCEL, 32'd32767, '0, CHK_PRED, '0},
    '{ROW_CFG, REG_START_ACCEL, 32'd32767, '0, CHK_PRED, '0},
    '{ROW_CFG, REG_CRUISE, 32'd32767, '0, CHK_PRED, '0},
    '{ROW_CFG, REG_SPEED_LIMIT, 32'd32767, '0, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd65535, POS_MAX, POS_MIN},
      CHK_FIXED, '{16'sd32767, 16'd61, 1'b1, 15'd32767}},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd65535, POS_MIN, POS_MAX},
      CHK_FIXED, '{-16'sd32767, 16'd61, 1'b0, 15'd32767}},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd65535, 32'sd5, 32'sd5},
      CHK_FIXED, '{16'sd0, 16'd65535, 1'b0, 15'd32767}},
    '{ROW_CFG, REG_IDLE_PERIOD, 32'd0, '0, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd0, 32'sd100, 32'sd0},
      CHK_FIXED, '{16'sd0, 16'd0, 1'b0, 15'd32767}},
    '{ROW_CFG, REG_MAX_ACCEL, 32'd1000, '0, CHK_PRED, '0},
    '{ROW_CFG, REG_START_ACCEL, 32'd100, '0, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd1000, 32'sd1000000, 32'sd0}, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd30000, 32'sd1000000, 32'sd10}, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd20000, 32'sd1000000, 32'sd500}, CHK_PRED, '0},
    '{ROW_CFG, REG_BRAKE_DIV, 32'd0, '0, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd500, 32'sd2000000, 32'sd900}, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd500, 32'sd0, 32'sd950}, CHK_PRED, '0},
    '{ROW_CFG, REG_START_ACCEL, 32'd0, '0, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd65535, 32'sd7, 32'sd7}, CHK_PRED, '0},
    '{ROW_CFG, REG_SPEED_LIMIT, 32'd0, '0, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd65535, POS_MAX, 32'sd0}, CHK_PRED, '0},
    '{ROW_TICK, REG_MAX_ACCEL, 32'd0, '{16'd1000, POS_MAX, 32'sd0}, CHK_PRED, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  cfg_t   cfg_q = CFG_RESET;
  longint speed_q = 0;
  bit     dir_q = 1'b0;
  out_t   speed_results[$];
  out_t   want;
  int     ticks_sent = 0;
  int     results_seen = 0;
  int     reg_writes = 0;
  int     mismatches = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;
  logic [11:0] sink_phase = '0;

  stepper_speed_ramp_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  function automatic out_t ramp_tick(in_t t);
    longint spd, abs_spd, accel, divisor, stop_mag, stop_dist, to_goal, target;
    longint lim, ramp, diff, period, goal, cur, top, bottom, knee, coef, cruise;
    out_t r;
    spd = speed_q;
    abs_spd = (spd < 0) ? -spd : spd;
    top = cfg_q.max_accel;
    bottom = cfg_q.start_accel;
    knee = cfg_q.low_speed_knee;
    coef = cfg_q.brake_div;
    cruise = cfg_q.cruise_speed;
    lim = cfg_q.speed_limit;
    if (abs_spd < knee) begin
      accel = abs_spd * (top - bottom) / knee + bottom;
    end else begin
      accel = top;
    end
    divisor = coef * accel;
    stop_mag = (divisor > 0) ? spd * spd / divisor : 64'sd4294967295;
    stop_dist = (spd > 0) ? stop_mag : ((spd < 0) ? -stop_mag : 0);
    goal = t.goal_step;
    cur = t.current_step;
    to_goal = goal - cur;
    if (goal > cur) begin
      target = (stop_dist >= to_goal) ? 0 : cruise;
    end else begin
      target = (stop_dist <= to_goal) ? 0 : -cruise;
    end
    if (target > lim) target = lim;
    if (target < -lim) target = -lim;
    ramp = accel * longint'(t.dt_us) / 1000;
    diff = target - spd;
    if (diff > ramp) begin
      spd = spd + ramp;
    end else if (diff < -ramp) begin
      spd = spd - ramp;
    end else begin
      spd = target;
    end
    speed_q = spd;
    if (spd > 0) dir_q = 1'b1;
    else if (spd < 0) dir_q = 1'b0;
    if (spd == 0) begin
      period = cfg_q.idle_period;
    end else begin
      period = 2000000 / ((spd < 0) ? -spd : spd);
      if (period > 65535) period = cfg_q.idle_period;
    end
    r.speed_out = spd[15:0];
    r.step_period = period[15:0];
    r.direction_level = dir_q;
    r.accel_used = accel[14:0];
    return r;
  endfunction

  task automatic note_fail(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  task automatic send_tick(input in_t t, input chk_e chk, input out_t fixed);
    int gap;
    out_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: gap = 0;
        1: gap = $urandom_range(1, 30);
        default: gap = $urandom_range(100, 250);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    predicted = ramp_tick(t);
    speed_results.push_back((chk == CHK_FIXED) ? fixed : predicted);
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (speed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_ACCEL:   cfg_q.max_accel = val[14:0];
      REG_CRUISE:      cfg_q.cruise_speed = val[14:0];
      REG_SPEED_LIMIT: cfg_q.speed_limit = val[14:0];
      REG_KNEE:        cfg_q.low_speed_knee = val[14:0];
      REG_START_ACCEL: cfg_q.start_accel = val[14:0];
      REG_BRAKE_DIV:   cfg_q.brake_div = val[7:0];
      REG_IDLE_PERIOD: cfg_q.idle_period = val[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  always @(posedge clk) begin
    sink_phase <= sink_phase + 1'b1;
    case (sink_phase[11:10])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (sink_phase[5:0] < 6'd16);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (speed_results.size() == 0) begin
        note_fail($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = speed_results.pop_front();
        if (want !== out_data) begin
          note_fail($sformatf({"result %0d: expected speed %0d period %0d dir %0b accel %0d,",
                               " got speed %0d period %0d dir %0b accel %0d"},
                              results_seen, want.speed_out, want.step_period,
                              want.direction_level, want.accel_used, out_data.speed_out,
                              out_data.step_period, out_data.direction_level,
                              out_data.accel_used));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_t   next_cfg;
    in_t    t;
    longint pos, goal, travel;
    int     seg_left, r, dt, jit;
    pos = 0;
    goal = 0;
    seg_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        send_tick(DIRECTED[i].tick, DIRECTED[i].chk, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      next_cfg = CFG_RESET;
      case (p)
        0: next_cfg.cruise_speed = 15'($urandom_range(2000, 20000));
        1: next_cfg = '{15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd1, 8'd1, 16'd0};
        2: next_cfg = '{15'd1, 15'($urandom_range(0, 32767)), 15'd1, 15'd1, 15'd32767,
                        8'd255, 16'd65535};
        3: next_cfg = '{15'd200, 15'd25000, 15'd30000, 15'd20000, 15'd5000,
                        8'($urandom_range(1, 8)), 16'($urandom)};
        default: begin
          next_cfg.max_accel = 15'($urandom_range(1, 32767));
          next_cfg.cruise_speed = 15'($urandom_range(0, 32767));
          next_cfg.speed_limit = 15'($urandom_range(1, 32767));
          next_cfg.low_speed_knee = 15'($urandom_range(1, 32767));
          next_cfg.start_accel = 15'($urandom_range(1, 32767));
          next_cfg.brake_div = 8'($urandom_range(1, 255));
          next_cfg.idle_period = 16'($urandom);
        end
      endcase
      drain_results();
      write_reg(REG_MAX_ACCEL, 32'(next_cfg.max_accel));
      write_reg(REG_CRUISE, 32'(next_cfg.cruise_speed));
      write_reg(REG_SPEED_LIMIT, 32'(next_cfg.speed_limit));
      write_reg(REG_KNEE, 32'(next_cfg.low_speed_knee));
      write_reg(REG_START_ACCEL, 32'(next_cfg.start_accel));
      write_reg(REG_BRAKE_DIV, 32'(next_cfg.brake_div));
      write_reg(REG_IDLE_PERIOD, 32'(next_cfg.idle_period));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 120);
          if (pos > 64'sd1000000000 || pos < -64'sd1000000000) pos = 0;
          case ($urandom_range(0, 2))
            0: travel = $urandom_range(0, 2000);
            1: travel = $urandom_range(0, 200000);
            default: travel = $urandom_range(0, 3000000);
          endcase
          goal = $urandom_range(0, 1) ? pos + travel : pos - travel;
        end
        seg_left--;
        r = $urandom_range(0, 99);
        dt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(50, 3000);
        jit = $urandom_range(0, 4);
        t.dt_us = 16'(dt);
        if (r < 8) begin
          t.dt_us = 16'($urandom);
          t.goal_step = $urandom;
          t.current_step = $urandom;
        end else if (r < 11) begin
          t.goal_step = $urandom;
          t.current_step = t.goal_step;
        end else begin
          t.goal_step = 32'(goal);
          t.current_step = 32'(pos + jit - 2);
        end
        pos = pos + speed_q * longint'(t.dt_us) / 1000000;
        send_tick(t, CHK_PRED, '0);
      end
    end

    in_valid <= 1'b0;
    while (speed_results.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Sent %0d ticks (directed rows, then %0d random register setups of %0d ticks).",
             ticks_sent, N_PHASES, PHASE_ITEMS);
    $display("Compared %0d results after %0d register writes; %0d mismatches.",
             results_seen, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/srr_pkg.sv
rtl/core/srr_regs.sv
rtl/core/srr_mul.sv
rtl/core/srr_div.sv
rtl/core/stepper_speed_ramp_top.sv
test/stepper_speed_ramp_top_tb.sv
